>>> design/pcfpl_pkg.sv
// ----------------------------------------------------------------------------
// pcfpl_pkg
// Shared codes and constants for the per-core free page list allocator.
// ----------------------------------------------------------------------------
package pcfpl_pkg;

	localparam int PAGE_SHIFT = 12;

	// request opcodes
	localparam logic OP_FREE  = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	// result status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_BAD_FREE = 2'd1;
	localparam logic [1:0] STAT_NO_MEM   = 2'd2;

	// configuration register indexes
	localparam logic REG_REGION_LOW  = 1'b0;
	localparam logic REG_REGION_HIGH = 1'b1;

	localparam logic [31:0] REGION_LOW_RST  = 32'h0000_0000;
	localparam logic [31:0] REGION_HIGH_RST = 32'h8800_0000;

	// width of the shared adder: two 33-bit operands plus a borrow bit
	localparam int ALU_W = 34;

	typedef logic [ALU_W-1:0] alu_word_t;

endpackage

>>> design/per_core_free_page_lists.sv
// ----------------------------------------------------------------------------
// per_core_free_page_lists
// Page allocator with one LIFO free list per core, linked through a
// next-link RAM; allocation falls back to the lowest non-empty other list.
// ----------------------------------------------------------------------------
//
//  channel   handshake        payload                     direction
//  request   start / busy     op, cpu, page_addr          in
//  result    done (strobe)    status, alloc_addr          out
//  config    cfg_we           cfg_idx, cfg_data           in
//
//  A request beat is taken when start is high and busy is low. One shared
//  34-bit adder does the range compares and the address arithmetic, one step
//  per cycle: a free runs LOW, HIGH, BASE, OFF, LIM; an allocate PICK, BASE,
//  ADDR; an out-of-memory allocate only PICK. done pulses for one cycle in
//  the first idle cycle; the receiver cannot stall, so no result is ever held
//  back. arst_n clears all lists (no clearing pass); the link RAM is not reset.
//
module per_core_free_page_lists
	import pcfpl_pkg::*;
#(
	parameter int CORES     = 8,
	parameter int MAX_PAGES = 32768
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [2:0]  cpu,
	input  logic [31:0] page_addr,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] alloc_addr,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [31:0] cfg_data
);

	localparam int CW     = (CORES > 1) ? $clog2(CORES) : 1;
	localparam int IDX_W  = $clog2(MAX_PAGES);
	localparam int LINK_W = $clog2(MAX_PAGES + 1);
	localparam logic [32:0] LIM_BYTES = 33'(MAX_PAGES) << PAGE_SHIFT;
	localparam logic [LINK_W-1:0] LINK_MAX = LINK_W'(MAX_PAGES);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOW  = 3'd1;
	localparam logic [2:0] ST_HIGH = 3'd2;
	localparam logic [2:0] ST_BASE = 3'd3;
	localparam logic [2:0] ST_OFF  = 3'd4;
	localparam logic [2:0] ST_LIM  = 3'd5;
	localparam logic [2:0] ST_PICK = 3'd6;
	localparam logic [2:0] ST_ADDR = 3'd7;

	logic [2:0]        state_q;
	logic              done_q;
	logic [31:0]       region_low_q;
	logic [31:0]       region_high_q;
	logic [CORES-1:0]  nonempty_q;
	logic [IDX_W-1:0]  head_q [CORES];

	logic              op_q;
	logic [CW-1:0]     core_q;
	logic [31:0]       addr_q;
	logic              lt_low_q;
	logic              lt_high_q;
	logic [32:0]       base_q;
	logic [32:0]       off_q;
	logic [CW-1:0]     pick_q;
	logic [IDX_W-1:0]  idx_q;
	logic [1:0]        status_q;
	logic [31:0]       alloc_addr_q;

	logic              accept;
	logic [CW-1:0]     core_in;
	logic [CW-1:0]     pick;
	logic              found;
	logic [CW-1:0]     hd_ridx;
	logic [CW-1:0]     hd_widx;
	logic [IDX_W-1:0]  hd_rdata;
	logic              free_ok;
	logic [IDX_W-1:0]  free_idx;
	logic [LINK_W-1:0] new_link;
	logic [LINK_W-1:0] rd_link;
	logic              link_ok;

	alu_word_t         alu_a;
	alu_word_t         alu_b;
	logic              alu_sub;
	alu_word_t         alu_r;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// core number folded into range; cpu is only 3 bits wide
	always_comb begin
		int r;
		r = int'(cpu);
		for (int i = 0; i < 8; i++) begin
			if (r >= CORES) begin
				r = r - CORES;
			end
		end
		core_in = CW'(r);
	end

	// own list first, else the lowest-numbered non-empty one
	always_comb begin
		pick  = core_q;
		found = |nonempty_q;
		if (!nonempty_q[core_q]) begin
			for (int c = CORES - 1; c >= 0; c--) begin
				if (nonempty_q[c]) begin
					pick = CW'(c);
				end
			end
		end
	end

	assign hd_ridx  = (state_q == ST_PICK) ? pick : core_q;
	assign hd_widx  = (state_q == ST_ADDR) ? pick_q : core_q;
	assign hd_rdata = head_q[hd_ridx];

	// shared adder / comparator; bit 33 is the borrow on a subtract
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			ST_LOW: begin
				alu_a   = ALU_W'(addr_q);
				alu_b   = ALU_W'(region_low_q);
				alu_sub = 1'b1;
			end
			ST_HIGH: begin
				alu_a   = ALU_W'(addr_q);
				alu_b   = ALU_W'(region_high_q);
				alu_sub = 1'b1;
			end
			ST_BASE: begin
				alu_a = ALU_W'(region_low_q);
				alu_b = ALU_W'(32'h0000_0FFF);
			end
			ST_OFF: begin
				alu_a   = ALU_W'(addr_q);
				alu_b   = ALU_W'(base_q);
				alu_sub = 1'b1;
			end
			ST_LIM: begin
				alu_a   = ALU_W'(off_q);
				alu_b   = ALU_W'(LIM_BYTES);
				alu_sub = 1'b1;
			end
			ST_ADDR: begin
				alu_a = ALU_W'(base_q);
				alu_b = ALU_W'({idx_q, {PAGE_SHIFT{1'b0}}});
			end
			default: begin
				alu_a   = '0;
				alu_b   = '0;
				alu_sub = 1'b0;
			end
		endcase
		alu_r = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
	end

	assign free_ok  = (addr_q[PAGE_SHIFT-1:0] == '0) && !lt_low_q && lt_high_q
		&& alu_r[ALU_W-1];
	assign free_idx = off_q[IDX_W+PAGE_SHIFT-1:PAGE_SHIFT];
	assign new_link = nonempty_q[core_q] ? (LINK_W'(hd_rdata) + LINK_W'(1)) : '0;
	assign link_ok  = (rd_link != '0) && (rd_link <= LINK_MAX);

	pcfpl_ram #(
		.WIDTH (LINK_W),
		.DEPTH (MAX_PAGES)
	) u_link_ram (
		.clk   (clk),
		.we    ((state_q == ST_LIM) && free_ok),
		.waddr (free_idx),
		.wdata (new_link),
		.re    ((state_q == ST_PICK) && found),
		.raddr (hd_rdata),
		.rdata (rd_link)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			done_q        <= 1'b0;
			region_low_q  <= REGION_LOW_RST;
			region_high_q <= REGION_HIGH_RST;
			nonempty_q    <= '0;
			for (int c = 0; c < CORES; c++) begin
				head_q[c] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_REGION_LOW:  region_low_q  <= cfg_data;
					REG_REGION_HIGH: region_high_q <= cfg_data;
					default:         region_low_q  <= region_low_q;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (op == OP_ALLOC) ? ST_PICK : ST_LOW;
					end
				end
				ST_LOW:  state_q <= ST_HIGH;
				ST_HIGH: state_q <= ST_BASE;
				ST_BASE: state_q <= (op_q == OP_ALLOC) ? ST_ADDR : ST_OFF;
				ST_OFF:  state_q <= ST_LIM;
				ST_LIM: begin
					if (free_ok) begin
						head_q[hd_widx]     <= free_idx;
						nonempty_q[hd_widx] <= 1'b1;
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_PICK: begin
					if (found) begin
						state_q <= ST_BASE;
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_ADDR: begin
					if (link_ok) begin
						head_q[hd_widx] <= IDX_W'(rd_link - LINK_W'(1));
					end else begin
						head_q[hd_widx]     <= '0;
						nonempty_q[hd_widx] <= 1'b0;
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op;
			core_q <= core_in;
			addr_q <= page_addr;
		end
		if (state_q == ST_LOW) begin
			lt_low_q <= alu_r[ALU_W-1];
		end
		if (state_q == ST_HIGH) begin
			lt_high_q <= alu_r[ALU_W-1];
		end
		if (state_q == ST_BASE) begin
			base_q <= {alu_r[32:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
		end
		if (state_q == ST_OFF) begin
			off_q <= alu_r[32:0];
		end
		if (state_q == ST_PICK) begin
			pick_q <= pick;
			idx_q  <= hd_rdata;
		end
		unique case (state_q)
			ST_LIM: begin
				status_q     <= free_ok ? STAT_OK : STAT_BAD_FREE;
				alloc_addr_q <= '0;
			end
			ST_PICK: begin
				status_q     <= STAT_NO_MEM;
				alloc_addr_q <= '0;
			end
			ST_ADDR: begin
				status_q     <= STAT_OK;
				alloc_addr_q <= alu_r[31:0];
			end
			default: begin
				status_q     <= status_q;
				alloc_addr_q <= alloc_addr_q;
			end
		endcase
	end

	assign done       = done_q;
	assign status     = status_q;
	assign alloc_addr = alloc_addr_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while sequencer still busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted request did not start the sequencer");

	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STAT_OK) |-> (alloc_addr == '0))
		else $error("failed request returned a page address");

	a_oom_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_NO_MEM) |-> (nonempty_q == '0))
		else $error("out of memory reported with a non-empty list");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADDR) |-> $past(found))
		else $error("pop started without a non-empty list");
`endif

endmodule

>>> design/pcfpl_ram.sv
// ----------------------------------------------------------------------------
// pcfpl_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcfpl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32768
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
